/* rtl/core/tile_row_copy_descriptor_generator_macros.svh */
// Assertion macros for the tile row copy descriptor generator.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef TILE_ROW_COPY_DESCRIPTOR_GENERATOR_MACROS_SVH
`define TILE_ROW_COPY_DESCRIPTOR_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRCDG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRCDG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/trcdg_pkg.sv */
// Shared types, constants and helper functions for the tile row copy descriptor generator.
// No dependencies; imported by every module of the block.
package trcdg_pkg;

   // Build-time geometry.
   localparam int CHANNELS    = 1;
   localparam int TILE_PLANES = 1;

   // Field and internal widths.
   localparam int SRC_W      = 48;
   localparam int COPY_W     = 18;
   localparam int DST_W      = 24;
   localparam int FROW_W     = 20;
   localparam int FPLANE_W   = 18;
   localparam int ROW_CNT_W  = 4;
   localparam int PLANE_CNT_W = 2;
   localparam int TH_W       = 5;
   localparam int SHIFT_W    = 2;
   localparam int FCOL_W     = 34;
   localparam int TH_MAX     = 16;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   // Configuration register indexes.
   localparam logic [2:0] REG_SAMPLE_TYPE  = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] REG_IMAGE_PLANES = 3'd3;
   localparam logic [2:0] REG_ROW_STRIDE   = 3'd4;
   localparam logic [2:0] REG_PLANE_STRIDE = 3'd5;
   localparam logic [2:0] REG_TILE_WIDTH   = 3'd6;
   localparam logic [2:0] REG_TILE_HEIGHT  = 3'd7;

   // Sample encodings.
   localparam logic [2:0] ST_U8  = 3'd0;
   localparam logic [2:0] ST_U16 = 3'd1;
   localparam logic [2:0] ST_I8  = 3'd2;
   localparam logic [2:0] ST_I16 = 3'd3;
   localparam logic [2:0] ST_F32 = 3'd4;
   localparam logic [2:0] ST_U10 = 3'd5;
   localparam logic [2:0] ST_U12 = 3'd6;
   localparam logic [2:0] ST_U14 = 3'd7;

   typedef struct packed {
      logic [2:0]  sample_type;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] image_planes;
      logic [31:0] row_stride;
      logic [31:0] plane_stride;
      logic [15:0] tile_span;
      logic [4:0]  tile_height;
   } cfg_type;

   // One tile request, fully classified by the front part.
   typedef struct packed {
      logic [SRC_W-1:0]    base;
      logic [FROW_W-1:0]   frow0;
      logic [FPLANE_W-1:0] fplane0;
      logic [COPY_W-1:0]   copy_bytes;
      logic [DST_W-1:0]    row_bytes;
      logic [TH_W-1:0]     rows;
      logic [SHIFT_W-1:0]  shift;
   } job_type;

   // One copy descriptor.
   typedef struct packed {
      logic [SRC_W-1:0]  src_byte_offset;
      logic [COPY_W-1:0] copy_bytes;
      logic [DST_W-1:0]  dst_byte_offset;
      logic              region_valid;
      logic              last_row;
   } desc_type;

   // Log2 of the bytes per sample for an encoding.
   function automatic logic [SHIFT_W-1:0] bps_shift(input logic [2:0] st);
      logic [SHIFT_W-1:0] sh;
      unique case (st) inside
         ST_U8, ST_I8: begin
            sh = 2'd0;
         end
         ST_F32: begin
            sh = 2'd2;
         end
         ST_U16, ST_I16, ST_U10, ST_U12, ST_U14: begin
            sh = 2'd1;
         end
         default: begin
            sh = 2'd1;
         end
      endcase
      return sh;
   endfunction

   // Tile height saturated to the largest supported value.
   function automatic logic [TH_W-1:0] sat_height(input logic [4:0] th);
      logic [TH_W-1:0] r;
      r = (th > TH_W'(TH_MAX)) ? TH_W'(TH_MAX) : th;
      return r;
   endfunction

endpackage

/* rtl/core/trcdg_front.sv */
// Front part: accepts tile requests and works out the per-request base values.
// Depends on trcdg_pkg; feeds trcdg_queue.
module trcdg_front
   import trcdg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] col_idx,
   input  logic [15:0] row_idx,
   input  logic [15:0] plane_idx,
   output logic        push,
   output job_type     push_job,
   input  logic        q_full
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_SCALE = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [15:0]         tcol_ff, trow_ff, tplane_ff;
   logic [31:0]         p1_ff;
   logic [FROW_W-1:0]   frow0_ff;
   logic [FPLANE_W-1:0] fplane0_ff;
   logic [FCOL_W-1:0]   fcol_ff;
   logic [SRC_W-1:0]    rterm_ff, pterm_ff, sum_ff;
   logic [COPY_W-1:0]   copy_ff;
   logic [DST_W-1:0]    row_bytes_ff;

   logic [TH_W-1:0]     th;
   logic [SHIFT_W-1:0]  shift;
   logic [20:0]         frow_prod;
   logic [51:0]         rprod;
   logic [49:0]         pprod;
   logic [16:0]         end_sum, end_clip, diff;
   logic                col_inside;
   logic [19:0]         tw_ch;

   assign th    = sat_height(cfg.tile_height);
   assign shift = bps_shift(cfg.sample_type);

   // Products for the first and second multiply steps.
   assign frow_prod = 21'(trow_ff) * 21'(th);
   assign rprod     = 52'(frow0_ff) * 52'(cfg.row_stride);
   assign pprod     = 50'(fplane0_ff) * 50'(cfg.plane_stride);

   // Width clip at the right image edge; zero when the column starts at or beyond it.
   assign col_inside = fcol_ff < FCOL_W'(cfg.image_width);
   assign end_sum    = 17'(fcol_ff[15:0]) + 17'(cfg.tile_span);
   assign end_clip   = (end_sum > 17'(cfg.image_width)) ? 17'(cfg.image_width) : end_sum;
   assign diff       = end_clip - 17'(fcol_ff[15:0]);
   assign tw_ch      = 20'(cfg.tile_span) * 20'(CHANNELS);

   assign req_ready = (state_ff == S_IDLE);
   assign push      = (state_ff == S_PUSH) && (th != '0) && !q_full;

   always_comb begin
      push_job            = '0;
      push_job.base       = sum_ff + pterm_ff;
      push_job.frow0      = frow0_ff;
      push_job.fplane0    = fplane0_ff;
      push_job.copy_bytes = copy_ff;
      push_job.row_bytes  = row_bytes_ff;
      push_job.rows       = th;
      push_job.shift      = shift;
   end

   // Request sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (th == '0 || !q_full) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers, one step of arithmetic per state.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         tcol_ff   <= col_idx;
         trow_ff   <= row_idx;
         tplane_ff <= plane_idx;
      end
      if (state_ff == S_MUL) begin
         p1_ff      <= 32'(tcol_ff) * 32'(cfg.tile_span);
         frow0_ff   <= frow_prod[FROW_W-1:0];
         fplane0_ff <= FPLANE_W'(18'(tplane_ff) * 18'(TILE_PLANES));
      end
      if (state_ff == S_SCALE) begin
         fcol_ff  <= FCOL_W'(p1_ff) * FCOL_W'(CHANNELS);
         rterm_ff <= rprod[SRC_W-1:0];
         pterm_ff <= pprod[SRC_W-1:0];
      end
      if (state_ff == S_SUM) begin
         sum_ff       <= SRC_W'(fcol_ff) + rterm_ff;
         copy_ff      <= col_inside ? (COPY_W'(diff) << shift) : '0;
         row_bytes_ff <= DST_W'(tw_ch) << shift;
      end
   end

endmodule

/* rtl/core/trcdg_queue.sv */
// Two-entry queue of classified tile requests between the front and back parts.
// Depends on trcdg_pkg.
module trcdg_queue
   import trcdg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_job
);

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

/* rtl/core/trcdg_back.sv */
// Back part: walks the rows and planes of one queued request and emits descriptors.
// Depends on trcdg_pkg; drains trcdg_queue.
module trcdg_back
   import trcdg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     job_valid,
   input  job_type  job,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output desc_type rsp_desc
);

   logic                   busy_ff;
   logic [ROW_CNT_W-1:0]   row_ff;
   logic [PLANE_CNT_W-1:0] plane_ff;
   logic [FROW_W-1:0]      frow_ff, frow0_ff;
   logic [FPLANE_W-1:0]    fplane_ff;
   logic [SRC_W-1:0]       cur_ff, pbase_ff;
   logic [DST_W-1:0]       dst_ff;
   logic [COPY_W-1:0]      copy_ff;
   logic [DST_W-1:0]       row_bytes_ff;
   logic [TH_W-1:0]        rows_ff;
   logic [SHIFT_W-1:0]     shift_ff;
   logic                   rsp_valid_ff;
   desc_type               rsp_desc_ff;

   logic advance, emit, row_end, last, valid;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign emit    = busy_ff && advance;
   assign pop     = !busy_ff && job_valid;
   assign row_end = ({1'b0, row_ff} == rows_ff - 1'b1);
   assign last    = row_end && (plane_ff == PLANE_CNT_W'(TILE_PLANES - 1));
   assign valid   = (frow_ff < FROW_W'(cfg.image_height))
                 && (fplane_ff < FPLANE_W'(cfg.image_planes));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_desc  = rsp_desc_ff;

   // Control: busy flag, counters and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         row_ff       <= '0;
         plane_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) rsp_valid_ff <= emit;
         if (pop) begin
            busy_ff  <= 1'b1;
            row_ff   <= '0;
            plane_ff <= '0;
         end else if (emit) begin
            if (last) busy_ff <= 1'b0;
            if (row_end) begin
               row_ff   <= '0;
               plane_ff <= plane_ff + 1'b1;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end
      end
   end

   // Running source index, frame row and plane, and destination offset.
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff       <= job.base;
         pbase_ff     <= job.base;
         frow_ff      <= job.frow0;
         frow0_ff     <= job.frow0;
         fplane_ff    <= job.fplane0;
         dst_ff       <= '0;
         copy_ff      <= job.copy_bytes;
         row_bytes_ff <= job.row_bytes;
         rows_ff      <= job.rows;
         shift_ff     <= job.shift;
      end else if (emit) begin
         dst_ff <= dst_ff + row_bytes_ff;
         if (row_end) begin
            pbase_ff  <= pbase_ff + SRC_W'(cfg.plane_stride);
            cur_ff    <= pbase_ff + SRC_W'(cfg.plane_stride);
            frow_ff   <= frow0_ff;
            fplane_ff <= fplane_ff + 1'b1;
         end else begin
            cur_ff  <= cur_ff + SRC_W'(cfg.row_stride);
            frow_ff <= frow_ff + 1'b1;
         end
      end
   end

   // Output register; holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_desc_ff.src_byte_offset <= valid ? (cur_ff << shift_ff) : '0;
         rsp_desc_ff.copy_bytes      <= valid ? copy_ff : '0;
         rsp_desc_ff.dst_byte_offset <= dst_ff;
         rsp_desc_ff.region_valid    <= valid;
         rsp_desc_ff.last_row        <= last;
      end
   end

endmodule

/* rtl/core/tile_row_copy_descriptor_generator.sv */
// Top level of the tile row copy descriptor generator: configuration registers,
// front part, request queue and back part. Depends on trcdg_pkg and the macros header.
//
// Usage: one transaction on the req_ channel carries a tile request (column, row,
// plane). For each request the block sends tile_height * TILE_PLANES descriptors on
// the rsp_ channel (tile height saturated to sixteen; none when it is zero), planes
// outermost and rows innermost; tlast marks the final descriptor of the request and
// tuser carries the region-valid flag.
// A request goes through the front's multiply, scale, sum and push states, the queue,
// the back part's load and its output register to its first descriptor. The front
// takes a new request only once it has pushed the last; the back part loads a request,
// then emits one descriptor per cycle while the receiver is ready.
// A two-entry queue lets the front classify the next request while the back works.
// Configuration is written through the csr_ port; write it only while the block is idle.
// The block itself does not enforce this. Reset returns the registers to their defaults
// and empties the queue and pipeline. When the receiver holds rsp_tready low, the output
// register keeps its descriptor, the back part pauses, and once the queue fills, req_tready stays low.
`include "tile_row_copy_descriptor_generator_macros.svh"

module tile_row_copy_descriptor_generator
   import trcdg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // col_idx [15:0], row_idx [31:16], plane_idx [47:32]
   // Descriptor channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // src_byte_offset [47:0], copy_bytes [65:48],
                                    // dst_byte_offset [89:66], zero fill [95:90]
   output logic        rsp_tuser,   // region_valid
   output logic        rsp_tlast,   // last_row
   // Configuration write port.
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     q_push, q_full, q_pop, q_valid;
   job_type  q_in_job, q_out_job;
   desc_type desc;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_type  <= 3'd0;
         cfg_ff.image_width  <= 16'd1;
         cfg_ff.image_height <= 16'd1;
         cfg_ff.image_planes <= 16'd1;
         cfg_ff.row_stride   <= 32'd0;
         cfg_ff.plane_stride <= 32'd0;
         cfg_ff.tile_span    <= 16'd1;
         cfg_ff.tile_height  <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_SAMPLE_TYPE:  cfg_ff.sample_type  <= csr_wdata[2:0];
            REG_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_wdata[15:0];
            REG_IMAGE_HEIGHT: cfg_ff.image_height <= csr_wdata[15:0];
            REG_IMAGE_PLANES: cfg_ff.image_planes <= csr_wdata[15:0];
            REG_ROW_STRIDE:   cfg_ff.row_stride   <= csr_wdata;
            REG_PLANE_STRIDE: cfg_ff.plane_stride <= csr_wdata;
            REG_TILE_WIDTH:   cfg_ff.tile_span    <= csr_wdata[15:0];
            REG_TILE_HEIGHT:  cfg_ff.tile_height  <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   trcdg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .col_idx   (req_tdata[15:0]),
      .row_idx   (req_tdata[31:16]),
      .plane_idx (req_tdata[47:32]),
      .push      (q_push),
      .push_job  (q_in_job),
      .q_full    (q_full)
   );

   trcdg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_in_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_out_job)
   );

   trcdg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (q_valid),
      .job       (q_out_job),
      .pop       (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_desc  (desc)
   );

   // Pack the descriptor onto the stream.
   assign rsp_tdata = {6'd0, desc.dst_byte_offset, desc.copy_bytes, desc.src_byte_offset};
   assign rsp_tuser = desc.region_valid;
   assign rsp_tlast = desc.last_row;

   // A descriptor outside the image carries no source offset and no byte count.
   `TRCDG_ASSERT_SAME(a_outside_empty, rsp_tvalid && !rsp_tuser, rsp_tdata[65:0] == '0, "data set")

   // The front never writes into a full queue.
   `TRCDG_ASSERT_SAME(a_no_queue_overflow, q_push, !q_full, "request queue overflow")

   // After accepting a request the front is busy classifying it.
   `TRCDG_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "early ready")

endmodule
